// File: hw/rtl/oledtl_pkg.sv
package oledtl_pkg;

    // Default sizing, overridable from the top level
    localparam int COLUMNS_PER_LINE_DEF = 21;
    localparam int CHUNK_BYTES_DEF      = 16;

    // Field widths
    localparam int OP_W    = 2;
    localparam int LINE_W  = 3;
    localparam int CH_W    = 8;
    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int REP_W   = 5;
    localparam int COL_W   = 5;
    localparam int STEP_W  = 5;
    localparam int GLYPH_W = 40;

    // Longest zero run a single result can carry
    localparam int REP_MAX = 31;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [LINE_W-1:0]  line_t;
    typedef logic [CH_W-1:0]    ch_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [REP_W-1:0]   rep_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [GLYPH_W-1:0] glyph_t;

    // Item opcodes
    localparam op_t OP_START = 2'd0;
    localparam op_t OP_CHAR  = 2'd1;
    localparam op_t OP_END   = 2'd2;

    // Bus bytes
    localparam byte_t CTRL_CMD      = 8'h00;
    localparam byte_t CTRL_DATA     = 8'h40;
    localparam byte_t CMD_COL_ADDR  = 8'h21;
    localparam byte_t CMD_PAGE_ADDR = 8'h22;
    localparam byte_t COL_FIRST     = 8'd0;
    localparam byte_t COL_LAST      = 8'd127;

    // First printable code; everything else draws as a space
    localparam ch_t CH_FIRST = 8'd32;

    // Config register
    localparam logic  REG_I2C_ADDR   = 1'b0;
    localparam addr_t I2C_ADDR_RESET = 7'd60;

    // Sequencer step counts
    localparam int CMD_STEPS  = 12;
    localparam int CHAR_STEPS = 7;
    localparam int PAD_TXNS   = 8;
    localparam int PAD_STEPS  = 2 * PAD_TXNS;

    // Byte source select for a datapath feed step
    typedef logic [2:0] src_t;
    localparam src_t SRC_ZERO  = 3'd0;
    localparam src_t SRC_CMD   = 3'd1;
    localparam src_t SRC_CTRL  = 3'd2;
    localparam src_t SRC_GLYPH = 3'd3;
    localparam src_t SRC_PAD   = 3'd4;

    typedef struct packed {
        logic       load_item;
        logic       col_clear;
        logic       col_inc;
        logic       col_fill;
        logic       pad_init;
        logic       pad_dec;
        logic       feed;
        logic       flush;
        src_t       src;
        logic [2:0] idx;
        logic       txn_begin;
        logic       txn_end;
    } cmd_t;

    typedef struct packed {
        logic step_ok;
        logic line_full;
        logic pad_left;
    } sts_t;

    typedef struct packed {
        logic  start_txn;
        addr_t target_address;
        byte_t data_byte;
        rep_t  repeat_res;
        logic  stop_txn;
        logic  last;
    } res_t;

    // 5x7 font, codes 32..127; column 0 in the top byte
    function automatic glyph_t font_row(input logic [6:0] idx);
        glyph_t row;
        case (idx)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100;
            7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h082A1C2A08;
            7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E;
            7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0008142241;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h4122140800;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E;
            7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936;
            7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C;
            7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090101;
            7'd39: row = 40'h3E41415132;
            7'd40: row = 40'h7F0808087F;
            7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01;
            7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040;
            7'd45: row = 40'h7F0204027F;
            7'd46: row = 40'h7F0408107F;
            7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906;
            7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101;
            7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F;
            7'd55: row = 40'h7F2018207F;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0304780403;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h00007F4141;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h41417F0000;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438;
            7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F;
            7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102;
            7'd71: row = 40'h085454543C;
            7'd72: row = 40'h7F08040478;
            7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00;
            7'd75: row = 40'h007F102844;
            7'd76: row = 40'h00417F4000;
            7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408;
            7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408;
            7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020;
            7'd85: row = 40'h3C4040207C;
            7'd86: row = 40'h1C2040201C;
            7'd87: row = 40'h3C4030403C;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44;
            7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000;
            7'd93: row = 40'h0041360800;
            7'd94: row = 40'h0804081008;
            7'd95: row = 40'h7F4141417F;
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

// File: hw/rtl/oledtl_if.sv
interface oledtl_text_if;
    import oledtl_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    line_t line;
    ch_t   ch;

    modport source (output valid, output op, output line, output ch, input ready);
    modport sink   (input valid, input op, input line, input ch, output ready);
endinterface

interface oledtl_bus_if;
    import oledtl_pkg::*;

    logic  valid;
    logic  ready;
    logic  start_txn;
    addr_t target_address;
    byte_t data_byte;
    rep_t  repeat_res;
    logic  stop_txn;
    logic  last;

    modport source (
        output valid, output start_txn, output target_address, output data_byte,
        output repeat_res, output stop_txn, output last, input ready
    );
    modport sink (
        input valid, input start_txn, input target_address, input data_byte,
        input repeat_res, input stop_txn, input last, output ready
    );
endinterface

// File: hw/rtl/oledtl_ctrl.sv
module oledtl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  oledtl_pkg::op_t   in_op,
    output logic              in_ready,
    input  oledtl_pkg::sts_t  sts,
    output oledtl_pkg::cmd_t  cmd
);
    import oledtl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMD   = 3'd1;
    localparam logic [2:0] ST_CHAR  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;
    step_t      step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    step_next     = '0;
                    case (in_op)
                        OP_START:
                        begin
                            cmd.col_clear = 1'b1;
                            state_next    = ST_CMD;
                        end
                        OP_CHAR:
                        begin
                            // full line: drop the character
                            if (!sts.line_full)
                            begin
                                cmd.col_inc = 1'b1;
                                state_next  = ST_CHAR;
                            end
                        end
                        OP_END:
                        begin
                            cmd.pad_init = 1'b1;
                            cmd.col_fill = 1'b1;
                            state_next   = ST_PAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // six two-byte command transactions
            ST_CMD:
            begin
                cmd.feed = 1'b1;
                cmd.idx  = step_reg[3:1];
                if (!step_reg[0])
                begin
                    cmd.src       = SRC_ZERO;
                    cmd.txn_begin = 1'b1;
                end
                else
                begin
                    cmd.src     = SRC_CMD;
                    cmd.txn_end = 1'b1;
                end
                if (sts.step_ok)
                begin
                    if (step_reg == step_t'(CMD_STEPS - 1))
                        state_next = ST_FLUSH;
                    else
                        step_next = step_reg + 1'b1;
                end
            end

            // 0x40, five glyph columns, spacer
            ST_CHAR:
            begin
                cmd.feed = 1'b1;
                cmd.idx  = 3'(step_reg - 1'b1);
                if (step_reg == '0)
                begin
                    cmd.src       = SRC_CTRL;
                    cmd.txn_begin = 1'b1;
                end
                else if (step_reg == step_t'(CHAR_STEPS - 1))
                begin
                    cmd.src     = SRC_ZERO;
                    cmd.txn_end = 1'b1;
                end
                else
                begin
                    cmd.src = SRC_GLYPH;
                end
                if (sts.step_ok)
                begin
                    if (step_reg == step_t'(CHAR_STEPS - 1))
                        state_next = ST_FLUSH;
                    else
                        step_next = step_reg + 1'b1;
                end
            end

            // pad transactions: 0x40 then one zero run of a chunk
            ST_PAD:
            begin
                if (!step_reg[0] && (!sts.pad_left || step_reg == step_t'(PAD_STEPS)))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.feed = 1'b1;
                    if (!step_reg[0])
                    begin
                        cmd.src       = SRC_CTRL;
                        cmd.txn_begin = 1'b1;
                    end
                    else
                    begin
                        cmd.src     = SRC_PAD;
                        cmd.txn_end = 1'b1;
                        cmd.pad_dec = sts.step_ok;
                    end
                    if (sts.step_ok)
                        step_next = step_reg + 1'b1;
                end
            end

            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (sts.step_ok)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/oledtl_dp.sv
module oledtl_dp #(
    parameter int COLUMNS_PER_LINE = oledtl_pkg::COLUMNS_PER_LINE_DEF,
    parameter int CHUNK_BYTES      = oledtl_pkg::CHUNK_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oledtl_pkg::cmd_t     cmd,
    input  oledtl_pkg::line_t    line,
    input  oledtl_pkg::ch_t      ch,
    input  oledtl_pkg::addr_t    i2c_address,
    output oledtl_pkg::sts_t     sts,
    oledtl_bus_if.source         bus
);
    import oledtl_pkg::*;

    localparam int CHUNK_MAX = (CHUNK_BYTES > REP_MAX) ? REP_MAX : CHUNK_BYTES;
    localparam int REM_W     = $clog2(COLUMNS_PER_LINE * 6 + 1);
    localparam int CMP_W     = (REM_W > REP_W) ? REM_W : REP_W;

    col_t             col_reg;
    line_t            line_reg;
    glyph_t           glyph_reg;
    logic [REM_W-1:0] rem_reg;

    res_t pend_reg;
    logic pend_valid_reg;
    res_t out_reg;
    logic out_valid_reg;

    logic [6:0]       glyph_idx;
    col_t             col_left;
    logic [REM_W-1:0] rem_init;
    logic [CMP_W-1:0] rem_ext;
    rep_t             chunk;
    byte_t            feed_byte;
    rep_t             feed_count;
    logic             line_full;
    logic             merge;
    logic             out_free;
    logic             step_ok;
    logic             push;
    res_t             push_word;

    // codes outside the printable range draw as a space
    assign glyph_idx = (ch < CH_FIRST || ch[7]) ? 7'd0 : 7'(ch - CH_FIRST);

    assign line_full = (col_reg >= col_t'(COLUMNS_PER_LINE));
    assign col_left  = col_t'(COLUMNS_PER_LINE) - col_reg;
    // six bytes per remaining character cell
    assign rem_init  = REM_W'({col_left, 2'b00}) + REM_W'({col_left, 1'b0});
    assign rem_ext   = CMP_W'(rem_reg);
    assign chunk     = (rem_ext > CMP_W'(CHUNK_MAX)) ? rep_t'(CHUNK_MAX) : rep_t'(rem_ext);

    always_comb
    begin
        feed_byte  = '0;
        feed_count = rep_t'(1);
        case (cmd.src)
            SRC_ZERO:  feed_byte = CTRL_CMD;
            SRC_CTRL:  feed_byte = CTRL_DATA;
            SRC_CMD:
            begin
                case (cmd.idx)
                    3'd0:    feed_byte = CMD_COL_ADDR;
                    3'd1:    feed_byte = COL_FIRST;
                    3'd2:    feed_byte = COL_LAST;
                    3'd3:    feed_byte = CMD_PAGE_ADDR;
                    default: feed_byte = byte_t'(line_reg);
                endcase
            end
            SRC_GLYPH:
            begin
                case (cmd.idx)
                    3'd0:    feed_byte = glyph_reg[39:32];
                    3'd1:    feed_byte = glyph_reg[31:24];
                    3'd2:    feed_byte = glyph_reg[23:16];
                    3'd3:    feed_byte = glyph_reg[15:8];
                    default: feed_byte = glyph_reg[7:0];
                endcase
            end
            SRC_PAD:
            begin
                feed_byte  = '0;
                feed_count = chunk;
            end
            default:
            begin
            end
        endcase
    end

    // a zero run in the same transaction folds into the held result
    assign merge    = cmd.feed && (feed_byte == '0) && pend_valid_reg
                      && (pend_reg.data_byte == '0) && !cmd.txn_begin;
    assign out_free = !out_valid_reg || bus.ready;
    assign step_ok  = (cmd.feed && (merge || !pend_valid_reg || out_free))
                      || (cmd.flush && (!pend_valid_reg || out_free));
    assign push     = pend_valid_reg && out_free
                      && ((cmd.feed && !merge) || cmd.flush);

    // the word pushed by the flush is the item's last
    always_comb
    begin
        push_word      = pend_reg;
        push_word.last = cmd.flush;
    end

    assign sts.step_ok   = step_ok;
    assign sts.line_full = line_full;
    assign sts.pad_left  = (rem_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.col_clear)
                col_reg <= '0;
            else if (cmd.col_inc)
                col_reg <= col_reg + 1'b1;
            else if (cmd.col_fill)
                col_reg <= col_t'(COLUMNS_PER_LINE);

            if (cmd.pad_init)
                rem_reg <= line_full ? '0 : rem_init;
            else if (cmd.pad_dec)
                rem_reg <= rem_reg - REM_W'(chunk);

            if (cmd.feed && step_ok && !merge)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush && step_ok)
                pend_valid_reg <= 1'b0;

            if (push)
                out_valid_reg <= 1'b1;
            else if (bus.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            line_reg  <= line;
            glyph_reg <= font_row(glyph_idx);
        end

        if (cmd.feed && step_ok)
        begin
            if (merge)
            begin
                pend_reg.repeat_res <= pend_reg.repeat_res + feed_count;
                pend_reg.stop_txn   <= pend_reg.stop_txn | cmd.txn_end;
            end
            else
            begin
                pend_reg.start_txn      <= cmd.txn_begin;
                pend_reg.target_address <= cmd.txn_begin ? i2c_address : '0;
                pend_reg.data_byte      <= feed_byte;
                pend_reg.repeat_res     <= feed_count;
                pend_reg.stop_txn       <= cmd.txn_end;
                pend_reg.last           <= 1'b0;
            end
        end

        if (push)
            out_reg <= push_word;
    end

    assign bus.valid          = out_valid_reg;
    assign bus.start_txn      = out_reg.start_txn;
    assign bus.target_address = out_reg.target_address;
    assign bus.data_byte      = out_reg.data_byte;
    assign bus.repeat_res     = out_reg.repeat_res;
    assign bus.stop_txn       = out_reg.stop_txn;
    assign bus.last           = out_reg.last;

endmodule

// File: hw/rtl/oled_text_line_byte_stream_core.sv
// Turns a text line into display-bus words for a page-addressed monochrome
// controller. Items are taken one at a time; a result word leaves when the
// bus side is ready, at most one word per sequencer step, as zero bytes fold
// into runs. After the accept cycle a start-line item runs 12 steps and a
// final flush; a character the 0x40 byte, five glyph columns, a spacer and
// the flush; an end-of-line item two steps per pad transaction, at most eight
// transactions, a check and the flush, on a full line just the check and the
// flush; a dropped character or unknown op nothing more. A step that pushes a
// word waits while the output register is full and the bus is not ready. A
// held result and an output register sit between sequencer and bus, so the
// next item is accepted while the last word still waits. The bus address
// register sits at byte offset 0 and resets to 60.
module oled_text_line_byte_stream_core #(
    parameter int COLUMNS_PER_LINE = oledtl_pkg::COLUMNS_PER_LINE_DEF,
    parameter int CHUNK_BYTES      = oledtl_pkg::CHUNK_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    oledtl_text_if.sink  text_in,
    oledtl_bus_if.source bus_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import oledtl_pkg::*;

    addr_t i2c_addr_reg;
    cmd_t  cmd;
    sts_t  sts;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_I2C_ADDR);
    assign prdata = (paddr[2] == REG_I2C_ADDR) ? 32'(i2c_addr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i2c_addr_reg <= I2C_ADDR_RESET;
        else if (cfg_wr)
            i2c_addr_reg <= pwdata[ADDR_W-1:0];
    end

    oledtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_op    (text_in.op),
        .in_ready (text_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oledtl_dp #(
        .COLUMNS_PER_LINE (COLUMNS_PER_LINE),
        .CHUNK_BYTES      (CHUNK_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .line        (text_in.line),
        .ch          (text_in.ch),
        .i2c_address (i2c_addr_reg),
        .sts         (sts),
        .bus         (bus_out)
    );

endmodule
